>>> hdl/hhr_pkg.sv
// ----------------------------------------------------------------------------
// hhr_pkg
// shared types, sector codes and helpers for the hsv hue rotation pipeline
// ----------------------------------------------------------------------------
package hhr_pkg;

    localparam int COMP_W   = 8;
    localparam int STEP_W   = 4;
    localparam int SECTOR_W = 3;

    // hue sectors of 60 degrees
    localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA_RED   = 3'd5;

    // starting sector for each dominant channel
    localparam logic [2:0] KBASE_RED   = 3'd0;
    localparam logic [2:0] KBASE_GREEN = 3'd2;
    localparam logic [2:0] KBASE_BLUE  = 3'd4;

    // red in the low bits
    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } pixel_t;

    // after max/min search: hue as 2d*kbase + w
    typedef struct packed {
        logic [COMP_W-1:0]  hi;
        logic [COMP_W-1:0]  lo;
        logic [COMP_W-1:0]  d;
        logic [2:0]         kbase;
        logic signed [10:0] w;
    } stage1_t;

    // after rotation: sector index (not yet wrapped) and fraction
    typedef struct packed {
        logic [COMP_W-1:0] hi;
        logic [COMP_W-1:0] lo;
        logic signed [4:0] k;
        logic [8:0]        fr;
    } stage2_t;

    // wrap a sector index in -1..12 into 0..5
    function automatic logic [SECTOR_W-1:0] wrap_sector(input logic signed [4:0] k);
        logic [3:0] ku;
        logic [3:0] res;
        ku = k[3:0];
        if (k[4]) begin
            res = 4'd5;
        end else if (ku >= 4'd12) begin
            res = ku - 4'd12;
        end else if (ku >= 4'd6) begin
            res = ku - 4'd6;
        end else begin
            res = ku;
        end
        return res[SECTOR_W-1:0];
    endfunction

endpackage

>>> hdl/hhr_skid.sv
// ----------------------------------------------------------------------------
// hhr_skid
// input skid stage, keeps the upstream ready a plain register output
// ----------------------------------------------------------------------------
module hhr_skid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            up_valid,
    output logic            up_ready,
    input  hhr_pkg::pixel_t up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output hhr_pkg::pixel_t dn_data
);

    logic            full_reg;
    logic            full_next;
    hhr_pkg::pixel_t hold_reg;

    assign up_ready = !full_reg;
    assign dn_valid = full_reg || up_valid;
    assign dn_data  = full_reg ? hold_reg : up_data;

    // park a request when the pipeline stalls
    always_comb begin
        full_next = full_reg;
        if (full_reg && dn_ready) begin
            full_next = 1'b0;
        end else if (!full_reg && up_valid && !dn_ready) begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!full_reg && up_valid && !dn_ready) begin
            hold_reg <= up_data;
        end
    end

endmodule

>>> hdl/hhr_analyze.sv
// ----------------------------------------------------------------------------
// hhr_analyze
// stage 1: max, min, spread and raw hue of the pixel
// ----------------------------------------------------------------------------
module hhr_analyze (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  hhr_pkg::pixel_t  in_pix,
    output logic             out_valid,
    output hhr_pkg::stage1_t out_st
);

    logic             valid_reg;
    hhr_pkg::stage1_t st_reg;
    hhr_pkg::stage1_t st_next;
    logic [10:0]      r2;
    logic [10:0]      g2;
    logic [10:0]      b2;

    assign r2 = {2'b00, in_pix.red, 1'b0};
    assign g2 = {2'b00, in_pix.green, 1'b0};
    assign b2 = {2'b00, in_pix.blue, 1'b0};

    // dominant channel picks base sector, ties go red then green
    always_comb begin
        st_next = '0;
        if (in_pix.red >= in_pix.green && in_pix.red >= in_pix.blue) begin
            st_next.hi    = in_pix.red;
            st_next.lo    = (in_pix.green < in_pix.blue) ? in_pix.green : in_pix.blue;
            st_next.kbase = hhr_pkg::KBASE_RED;
            st_next.w     = $signed(g2) - $signed(b2);
        end else if (in_pix.green >= in_pix.blue) begin
            st_next.hi    = in_pix.green;
            st_next.lo    = (in_pix.red < in_pix.blue) ? in_pix.red : in_pix.blue;
            st_next.kbase = hhr_pkg::KBASE_GREEN;
            st_next.w     = $signed(b2) - $signed(r2);
        end else begin
            st_next.hi    = in_pix.blue;
            st_next.lo    = (in_pix.red < in_pix.green) ? in_pix.red : in_pix.green;
            st_next.kbase = hhr_pkg::KBASE_BLUE;
            st_next.w     = $signed(r2) - $signed(g2);
        end
        st_next.d = st_next.hi - st_next.lo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

>>> hdl/hhr_rotate.sv
// ----------------------------------------------------------------------------
// hhr_rotate
// stage 2: add the hue step and bring the fraction into [0, 2d)
// ----------------------------------------------------------------------------
module hhr_rotate (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [hhr_pkg::STEP_W-1:0]  hue_step,
    input  logic                        in_valid,
    input  hhr_pkg::stage1_t            in_st,
    output logic                        out_valid,
    output hhr_pkg::stage2_t            out_st
);

    logic             valid_reg;
    hhr_pkg::stage2_t st_reg;
    hhr_pkg::stage2_t st_next;
    logic signed [10:0] w_step;
    logic signed [10:0] w_norm;
    logic signed [10:0] two_d;
    logic signed [4:0]  k_adj;
    logic signed [4:0]  k_raw;

    assign two_d = $signed({2'b00, in_st.d, 1'b0});

    // an odd step adds half a sector, the even part moves whole sectors
    assign w_step = hue_step[0] ? (in_st.w + $signed({3'b000, in_st.d})) : in_st.w;
    assign k_raw  = $signed({2'b00, in_st.kbase}) + $signed({2'b00, hue_step[3:1]});

    // one borrow or carry into the sector index
    always_comb begin
        if (w_step < 0) begin
            w_norm = w_step + two_d;
            k_adj  = -5'sd1;
        end else if (w_step >= two_d) begin
            w_norm = w_step - two_d;
            k_adj  = 5'sd1;
        end else begin
            w_norm = w_step;
            k_adj  = 5'sd0;
        end
        st_next.hi = in_st.hi;
        st_next.lo = in_st.lo;
        st_next.k  = k_raw + k_adj;
        st_next.fr = w_norm[8:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

>>> hdl/hhr_rebuild.sv
// ----------------------------------------------------------------------------
// hhr_rebuild
// stage 3: wrap the sector, form q and t, rebuild rgb into the output register
// ----------------------------------------------------------------------------
module hhr_rebuild (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  hhr_pkg::stage2_t in_st,
    output logic             out_valid,
    output hhr_pkg::pixel_t  out_pix
);

    logic                           valid_reg;
    hhr_pkg::pixel_t                pix_reg;
    hhr_pkg::pixel_t                pix_next;
    logic [hhr_pkg::SECTOR_W-1:0]   sector;
    logic [9:0]                     fr_up;
    logic [hhr_pkg::COMP_W-1:0]     q;
    logic [hhr_pkg::COMP_W-1:0]     t;

    assign sector = hhr_pkg::wrap_sector(in_st.k);
    assign fr_up  = {1'b0, in_st.fr} + 10'd1;
    assign q      = in_st.hi - fr_up[8:1];
    assign t      = in_st.lo + in_st.fr[8:1];

    // per sector channel selection
    always_comb begin
        case (sector)
            hhr_pkg::SECTOR_RED_YELLOW: begin
                pix_next = '{blue: in_st.lo, green: t, red: in_st.hi};
            end
            hhr_pkg::SECTOR_YELLOW_GREEN: begin
                pix_next = '{blue: in_st.lo, green: in_st.hi, red: q};
            end
            hhr_pkg::SECTOR_GREEN_CYAN: begin
                pix_next = '{blue: t, green: in_st.hi, red: in_st.lo};
            end
            hhr_pkg::SECTOR_CYAN_BLUE: begin
                pix_next = '{blue: in_st.hi, green: q, red: in_st.lo};
            end
            hhr_pkg::SECTOR_BLUE_MAGENTA: begin
                pix_next = '{blue: in_st.hi, green: in_st.lo, red: t};
            end
            default: begin
                pix_next = '{blue: q, green: in_st.lo, red: in_st.hi};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

>>> hdl/hsv_hue_rotate_pixel_core.sv
// ----------------------------------------------------------------------------
// hsv_hue_rotate_pixel_core
// rotates the hsv hue of an 8-bit rgb pixel by a multiple of 30 degrees
// ----------------------------------------------------------------------------
//  channel   dir   payload                                   handshake
//  s_        in    tdata: red[7:0] green[15:8] blue[23:16]   s_tvalid / s_tready
//  m_        out   tdata: red[7:0] green[15:8] blue[23:16]   m_tvalid / m_tready
//  cfg_      in    wr_data: hue_step[3:0]                    cfg_wr_en, no wait
//
//  one pixel per clock sustained while m_tready is high; an accepted request
//  passes the analyze, rotate and rebuild register stages before m_tvalid rises.
//  aresetn is synchronous; it clears valid bits, the skid stage and hue_step.
//  a stall at m_tready freezes all three stages together; the input skid
//  register absorbs the one request in flight so s_tready is a register.
// ----------------------------------------------------------------------------
module hsv_hue_rotate_pixel_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // hue_step[3:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // red_out[7:0], green_out[15:8], blue_out[23:16]
);

    logic [hhr_pkg::STEP_W-1:0] hue_step_reg;
    logic                       en;
    logic                       pipe_valid;
    hhr_pkg::pixel_t            pipe_pix;
    logic                       s1_valid;
    hhr_pkg::stage1_t           s1_st;
    logic                       s2_valid;
    hhr_pkg::stage2_t           s2_st;
    hhr_pkg::pixel_t            out_pix;

    // hue step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_step_reg <= '0;
        end else if (cfg_wr_en) begin
            hue_step_reg <= cfg_wr_data;
        end
    end

    // pipeline advances unless a result is waiting downstream
    assign en = !m_tvalid || m_tready;

    hhr_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .up_data  (hhr_pkg::pixel_t'(s_tdata)),
        .dn_valid (pipe_valid),
        .dn_ready (en),
        .dn_data  (pipe_pix)
    );

    hhr_analyze u_analyze (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pipe_valid),
        .in_pix    (pipe_pix),
        .out_valid (s1_valid),
        .out_st    (s1_st)
    );

    hhr_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .hue_step  (hue_step_reg),
        .in_valid  (s1_valid),
        .in_st     (s1_st),
        .out_valid (s2_valid),
        .out_st    (s2_st)
    );

    hhr_rebuild u_rebuild (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_valid),
        .in_st     (s2_st),
        .out_valid (m_tvalid),
        .out_pix   (out_pix)
    );

    assign m_tdata = out_pix;

    // stalled pipeline keeps its valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(s1_valid) && $stable(s2_valid)))
        else $error("pipeline valid bits moved during a stall");

    // normalized fraction stays below one sector, zero for gray
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid |-> (({1'b0, s2_st.fr} < {1'b0, s2_st.hi - s2_st.lo, 1'b0})
                      || (s2_st.hi == s2_st.lo && s2_st.fr == 9'd0)))
        else $error("hue fraction out of range after rotation");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
